@@ design/pol_pkg.sv @@
// shared types, kind codes and byte classification for the punctuation and operator lexer
package pol_pkg;

   // token kinds
   localparam logic [4:0] KIND_RPAREN    = 5'd0;
   localparam logic [4:0] KIND_LPAREN    = 5'd1;
   localparam logic [4:0] KIND_RBRACKET  = 5'd2;
   localparam logic [4:0] KIND_LBRACKET  = 5'd3;
   localparam logic [4:0] KIND_RBRACE    = 5'd4;
   localparam logic [4:0] KIND_LBRACE    = 5'd5;
   localparam logic [4:0] KIND_PLUS      = 5'd6;
   localparam logic [4:0] KIND_MINUS     = 5'd7;
   localparam logic [4:0] KIND_STAR      = 5'd8;
   localparam logic [4:0] KIND_SLASH     = 5'd9;
   localparam logic [4:0] KIND_PERCENT   = 5'd10;
   localparam logic [4:0] KIND_DOT       = 5'd11;
   localparam logic [4:0] KIND_COMMA     = 5'd12;
   localparam logic [4:0] KIND_SEMICOLON = 5'd13;
   localparam logic [4:0] KIND_COLON     = 5'd14;
   localparam logic [4:0] KIND_BANG      = 5'd15;
   localparam logic [4:0] KIND_EQUAL     = 5'd17;
   localparam logic [4:0] KIND_GREATER   = 5'd19;
   localparam logic [4:0] KIND_LESS      = 5'd21;
   localparam logic [4:0] KIND_END       = 5'd23;
   localparam logic [4:0] KIND_ERROR     = 5'd24;

   // source bytes with special handling
   localparam logic [7:0] CHAR_TAB     = 8'h09;
   localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
   localparam logic [7:0] CHAR_CR      = 8'h0D;
   localparam logic [7:0] CHAR_SPACE   = 8'h20;
   localparam logic [7:0] CHAR_BANG    = 8'h21;
   localparam logic [7:0] CHAR_SLASH   = 8'h2F;
   localparam logic [7:0] CHAR_LESS    = 8'h3C;
   localparam logic [7:0] CHAR_EQUAL   = 8'h3D;
   localparam logic [7:0] CHAR_GREATER = 8'h3E;

   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);

   typedef enum logic [6:0] {
      MODE_NORMAL  = 7'b0000001,
      MODE_BANG    = 7'b0000010,
      MODE_EQUAL   = 7'b0000100,
      MODE_GREATER = 7'b0001000,
      MODE_LESS    = 7'b0010000,
      MODE_SLASH   = 7'b0100000,
      MODE_COMMENT = 7'b1000000
   } mode_type;

   typedef struct packed {
      logic [4:0]  kind;
      logic [15:0] line;
      logic [23:0] offset;
      logic [1:0]  length;
      logic [7:0]  bad;
      logic        last;
   } token_type;

   typedef struct packed {
      logic [1:0] count;
      token_type  first;
      token_type  second;
   } scan_result_type;

   // {hit, kind} for bytes that form a whole token on their own
   function automatic logic [5:0] single_kind(input logic [7:0] b);
      logic [5:0] r;
      case (b)
         8'h29: r = {1'b1, KIND_RPAREN};     // )
         8'h28: r = {1'b1, KIND_LPAREN};     // (
         8'h5D: r = {1'b1, KIND_RBRACKET};   // ]
         8'h5B: r = {1'b1, KIND_LBRACKET};   // [
         8'h7D: r = {1'b1, KIND_RBRACE};     // }
         8'h7B: r = {1'b1, KIND_LBRACE};     // {
         8'h2B: r = {1'b1, KIND_PLUS};       // +
         8'h2D: r = {1'b1, KIND_MINUS};      // -
         8'h2A: r = {1'b1, KIND_STAR};       // *
         8'h25: r = {1'b1, KIND_PERCENT};    // %
         8'h2E: r = {1'b1, KIND_DOT};        // .
         8'h2C: r = {1'b1, KIND_COMMA};      // ,
         8'h3B: r = {1'b1, KIND_SEMICOLON};  // ;
         8'h3A: r = {1'b1, KIND_COLON};      // :
         default: r = {1'b0, KIND_ERROR};
      endcase
      return r;
   endfunction

   // one-character kind of a held operator
   function automatic logic [4:0] pending_kind(input mode_type m);
      logic [4:0] k;
      case (m)
         MODE_BANG:    k = KIND_BANG;
         MODE_EQUAL:   k = KIND_EQUAL;
         MODE_GREATER: k = KIND_GREATER;
         MODE_LESS:    k = KIND_LESS;
         default:      k = KIND_SLASH;
      endcase
      return k;
   endfunction

endpackage

@@ design/pol_scan.sv @@
// scanner state and per-byte classification, giving up to two tokens per word
module pol_scan #(
   parameter int OFFSET_WIDTH = 24,
   parameter int LINE_WIDTH   = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     take,
   input  logic [7:0]               symbol,
   input  logic                     end_of_source,
   input  logic                     csr_we,
   input  logic [15:0]              csr_wdata,
   output pol_pkg::scan_result_type result
);

   localparam logic [31:0] LINE_MAX = 32'((64'd1 << LINE_WIDTH) - 64'd1);

   pol_pkg::mode_type       mode_ff, mode_in;
   logic [OFFSET_WIDTH-1:0] pos_ff, pos_in;
   logic [OFFSET_WIDTH-1:0] pstart_ff, pstart_in;
   logic [LINE_WIDTH-1:0]   line_ff, line_in;
   logic [15:0]             start_ff, start_in;

   logic [OFFSET_WIDTH-1:0] pos_bump;
   logic [LINE_WIDTH-1:0]   line_bump;
   logic [LINE_WIDTH-1:0]   start_clamped;
   logic [LINE_WIDTH-1:0]   wdata_clamped;
   logic [31:0]             pos_w, pstart_w, line_w;
   logic [5:0]              single;
   logic                    is_pending;
   logic                    combine, to_comment, stay_comment, flush_hit, normal_go;
   logic                    sym_opens, sym_ws, sym_nl;
   pol_pkg::mode_type       sym_mode;
   pol_pkg::token_type      tok_a, tok_b;
   logic                    a_valid, b_valid;

   function automatic logic [LINE_WIDTH-1:0] clamp_line(input logic [15:0] v);
      logic [31:0] v32;
      logic [LINE_WIDTH-1:0] r;
      v32 = 32'(v);
      if (v32 > LINE_MAX) begin
         r = '1;
      end else begin
         r = v32[LINE_WIDTH-1:0];
      end
      return r;
   endfunction

   assign pos_bump      = (pos_ff == '1) ? pos_ff : pos_ff + OFFSET_WIDTH'(1);
   assign line_bump     = (line_ff == '1) ? line_ff : line_ff + LINE_WIDTH'(1);
   assign start_clamped = clamp_line(start_ff);
   assign wdata_clamped = clamp_line(csr_wdata);
   assign pos_w         = 32'(pos_ff);
   assign pstart_w      = 32'(pstart_ff);
   assign line_w        = 32'(line_ff);
   assign single        = pol_pkg::single_kind(symbol);

   // what a byte does in normal mode
   always_comb begin
      sym_opens = 1'b1;
      sym_mode  = pol_pkg::MODE_NORMAL;
      case (symbol)
         pol_pkg::CHAR_BANG:    sym_mode = pol_pkg::MODE_BANG;
         pol_pkg::CHAR_EQUAL:   sym_mode = pol_pkg::MODE_EQUAL;
         pol_pkg::CHAR_GREATER: sym_mode = pol_pkg::MODE_GREATER;
         pol_pkg::CHAR_LESS:    sym_mode = pol_pkg::MODE_LESS;
         pol_pkg::CHAR_SLASH:   sym_mode = pol_pkg::MODE_SLASH;
         default:               sym_opens = 1'b0;
      endcase
   end

   assign sym_ws = (symbol == pol_pkg::CHAR_SPACE) || (symbol == pol_pkg::CHAR_TAB) ||
                   (symbol == pol_pkg::CHAR_CR);
   assign sym_nl = (symbol == pol_pkg::CHAR_NEWLINE);

   always_comb begin
      is_pending   = 1'b0;
      combine      = 1'b0;
      to_comment   = 1'b0;
      stay_comment = 1'b0;
      flush_hit    = 1'b0;
      normal_go    = 1'b0;
      case (mode_ff)
         pol_pkg::MODE_BANG, pol_pkg::MODE_EQUAL,
         pol_pkg::MODE_GREATER, pol_pkg::MODE_LESS: begin
            is_pending = 1'b1;
            if (symbol == pol_pkg::CHAR_EQUAL) begin
               combine = 1'b1;
            end else begin
               flush_hit = 1'b1;
               normal_go = 1'b1;
            end
         end
         pol_pkg::MODE_SLASH: begin
            is_pending = 1'b1;
            if (symbol == pol_pkg::CHAR_SLASH) begin
               to_comment = 1'b1;
            end else begin
               flush_hit = 1'b1;
               normal_go = 1'b1;
            end
         end
         pol_pkg::MODE_COMMENT: begin
            // the newline that closes a comment is scanned normally
            if (sym_nl) begin
               normal_go = 1'b1;
            end else begin
               stay_comment = 1'b1;
            end
         end
         default: begin
            normal_go = 1'b1;
         end
      endcase
   end

   // token a: held operator (flushed or combined); token b: this byte or the end token
   always_comb begin
      tok_a.kind   = pol_pkg::pending_kind(mode_ff);
      tok_a.line   = line_w[15:0];
      tok_a.offset = pstart_w[23:0];
      tok_a.length = 2'd1;
      tok_a.bad    = 8'd0;
      tok_a.last   = 1'b0;
      tok_b.line   = line_w[15:0];
      tok_b.offset = pos_w[23:0];
      tok_b.length = 2'd1;
      tok_b.bad    = 8'd0;
      tok_b.last   = 1'b1;
      tok_b.kind   = single[4:0];
      if (end_of_source) begin
         a_valid      = is_pending;
         b_valid      = 1'b1;
         tok_b.kind   = pol_pkg::KIND_END;
         tok_b.length = 2'd0;
      end else if (combine) begin
         a_valid      = 1'b1;
         b_valid      = 1'b0;
         tok_a.kind   = pol_pkg::pending_kind(mode_ff) + 5'd1;
         tok_a.length = 2'd2;
      end else begin
         a_valid = flush_hit;
         b_valid = normal_go && !sym_opens && !sym_ws && !sym_nl;
         if (!single[5]) begin
            tok_b.bad = symbol;
         end
      end
   end

   always_comb begin
      result.count = {1'b0, a_valid} + {1'b0, b_valid};
      result.first = a_valid ? tok_a : tok_b;
      if (a_valid) begin
         result.first.last = !b_valid;
      end
      result.second = tok_b;
   end

   always_comb begin
      mode_in   = mode_ff;
      pos_in    = pos_ff;
      pstart_in = pstart_ff;
      line_in   = line_ff;
      start_in  = start_ff;
      if (csr_we) begin
         start_in = csr_wdata;
      end
      if (take) begin
         if (end_of_source) begin
            mode_in   = pol_pkg::MODE_NORMAL;
            pos_in    = '0;
            pstart_in = '0;
            line_in   = start_clamped;
         end else begin
            pos_in = pos_bump;
            if (to_comment || stay_comment) begin
               mode_in = pol_pkg::MODE_COMMENT;
            end else if (normal_go) begin
               mode_in = sym_mode;
               if (sym_opens) begin
                  pstart_in = pos_ff;
               end
               if (sym_nl) begin
                  line_in = line_bump;
               end
            end else begin
               mode_in = pol_pkg::MODE_NORMAL;
            end
         end
      end else if (csr_we && (pos_ff == '0)) begin
         line_in = wdata_clamped;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= pol_pkg::MODE_NORMAL;
         pos_ff    <= '0;
         pstart_ff <= '0;
         start_ff  <= 16'd1;
         line_ff   <= LINE_WIDTH'(1);
      end else begin
         mode_ff   <= mode_in;
         pos_ff    <= pos_in;
         pstart_ff <= pstart_in;
         start_ff  <= start_in;
         line_ff   <= line_in;
      end
   end

endmodule

@@ design/punctuation_operator_lexer.sv @@
// top level of the punctuation and operator lexer: scanner plus result queue
//
// Source bytes enter on the req_ channel, one word per byte; req_tuser high
// marks end of source instead of a byte (req_tdata is then ignored). Tokens
// leave on the rsp_ channel with the kind on rsp_tuser and rsp_tlast set on
// the final token caused by an input word. A word gives zero, one or two
// tokens; the held operators ! = > < and / wait for the next byte.
// A token is written into the result queue when the word that caused it is
// taken, and rsp_ presents the queue head. Input takes one byte per cycle
// while req_tready is high; a word that gives two tokens needs two transfers
// on the rsp_ side, which the four-entry result queue absorbs. req_tready is
// high while the queue has room for two tokens, so input keeps flowing while
// results wait; a stalled receiver holds off input once three are queued.
// csr_wdata written with csr_we sets the first line number of each source;
// it also reloads the current line when no byte of the source is taken yet.
// Reset empties the queue, clears offsets and mode, and sets the start line
// to 1. Offsets and line numbers saturate at their maximum.
module punctuation_operator_lexer #(
   parameter int OFFSET_WIDTH = 24,
   parameter int LINE_WIDTH   = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // symbol
   input  logic        req_tuser,   // end_of_source
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [55:0] rsp_tdata,   // line_of_token, start_offset, lexeme_length, bad_symbol
   output logic [4:0]  rsp_tuser,   // token_kind
   output logic        rsp_tlast,   // last_of_run
   input  logic        csr_we,
   input  logic [15:0] csr_wdata
);

   localparam int PW = pol_pkg::QUEUE_PTR_W;

   pol_pkg::scan_result_type scan_res;
   pol_pkg::token_type       queue_ff [pol_pkg::QUEUE_DEPTH];
   pol_pkg::token_type       head;
   logic [PW-1:0]            wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]            rd_ptr_ff, rd_ptr_in;
   logic [PW:0]              count_ff, count_in;
   logic                     req_take, rsp_take;

   assign req_take = req_tvalid && req_tready;
   assign rsp_take = rsp_tvalid && rsp_tready;

   pol_scan #(
      .OFFSET_WIDTH(OFFSET_WIDTH),
      .LINE_WIDTH  (LINE_WIDTH)
   ) u_scan (
      .clock        (clock),
      .reset        (reset),
      .take         (req_take),
      .symbol       (req_tdata),
      .end_of_source(req_tuser),
      .csr_we       (csr_we),
      .csr_wdata    (csr_wdata),
      .result       (scan_res)
   );

   // room for the two tokens a word can produce
   assign req_tready = (count_ff <= (PW+1)'(pol_pkg::QUEUE_DEPTH - 2));

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (req_take) begin
         wr_ptr_in = wr_ptr_ff + PW'(scan_res.count);
         count_in  = count_in + (PW+1)'(scan_res.count);
      end
      if (rsp_take) begin
         rd_ptr_in = rd_ptr_ff + PW'(1);
         count_in  = count_in - (PW+1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take && (scan_res.count != 2'd0)) begin
         queue_ff[wr_ptr_ff] <= scan_res.first;
      end
      if (req_take && (scan_res.count == 2'd2)) begin
         queue_ff[wr_ptr_ff + PW'(1)] <= scan_res.second;
      end
   end

   assign head       = queue_ff[rd_ptr_ff];
   assign rsp_tvalid = (count_ff != '0);
   assign rsp_tdata  = {6'd0, head.bad, head.length, head.offset, head.line};
   assign rsp_tuser  = head.kind;
   assign rsp_tlast  = head.last;

`ifndef SYNTH
   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= (PW+1)'(pol_pkg::QUEUE_DEPTH))
      else $error("result queue overflow");

   a_eos_gives_token: assert property (@(posedge clock) disable iff (reset)
      (req_take && req_tuser) |=> (count_ff != '0))
      else $error("end of source produced no token");

   a_end_token_shape: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && (rsp_tuser == pol_pkg::KIND_END)) |->
      (rsp_tlast && (rsp_tdata[41:40] == 2'd0)))
      else $error("end token not last or not empty");

   a_count_moves: assert property (@(posedge clock) disable iff (reset)
      (!req_take && rsp_take) |=> (count_ff == $past(count_ff) - (PW+1)'(1)))
      else $error("queue count out of step");
`endif

endmodule

@@ verif/testbench.sv @@
// self-checking testbench for the punctuation and operator lexer
`timescale 1ns / 1ps

module testbench;

   // keeps the lexer state in step with the block and holds the tokens still due
   class token_predictor;
      pol_pkg::token_type expected_tokens[$];
      pol_pkg::mode_type  mode;
      logic [4:0]  held;
      logic [23:0] position;
      logic [23:0] held_start;
      logic [15:0] line;
      logic [15:0] first_line;
      int          failures;

      function new();
         mode       = pol_pkg::MODE_NORMAL;
         held       = pol_pkg::KIND_SLASH;
         position   = '0;
         held_start = '0;
         first_line = 16'd1;
         line       = 16'd1;
         failures   = 0;
      endfunction

      function void set_first_line(logic [15:0] value);
         first_line = value;
         if (position == '0) line = value;
      endfunction

      function void advance();
         if (position != '1) position = position + 24'd1;
      endfunction

      function void add(logic [4:0] kind, logic [23:0] off, logic [1:0] len, logic [7:0] bad);
         pol_pkg::token_type t;
         t.kind   = kind;
         t.line   = line;
         t.offset = off;
         t.length = len;
         t.bad    = bad;
         t.last   = 1'b0;
         expected_tokens = {expected_tokens, t};
      endfunction

      function void hold(pol_pkg::mode_type m, logic [4:0] kind, logic [23:0] at);
         mode       = m;
         held       = kind;
         held_start = at;
      endfunction

      function logic [4:0] solo_kind(logic [7:0] sym);
         case (sym)
            ")": return pol_pkg::KIND_RPAREN;
            "(": return pol_pkg::KIND_LPAREN;
            "]": return pol_pkg::KIND_RBRACKET;
            "[": return pol_pkg::KIND_LBRACKET;
            "}": return pol_pkg::KIND_RBRACE;
            "{": return pol_pkg::KIND_LBRACE;
            "+": return pol_pkg::KIND_PLUS;
            "-": return pol_pkg::KIND_MINUS;
            "*": return pol_pkg::KIND_STAR;
            "%": return pol_pkg::KIND_PERCENT;
            ".": return pol_pkg::KIND_DOT;
            ",": return pol_pkg::KIND_COMMA;
            ";": return pol_pkg::KIND_SEMICOLON;
            ":": return pol_pkg::KIND_COLON;
            default: return pol_pkg::KIND_ERROR;
         endcase
      endfunction

      function void scan_byte(logic [7:0] sym);
         logic [23:0] here;
         logic [4:0]  kind;
         here = position;
         kind = solo_kind(sym);
         advance();
         if (kind != pol_pkg::KIND_ERROR) begin
            add(kind, here, 2'd1, 8'd0);
         end else begin
            case (sym)
               pol_pkg::CHAR_BANG:
                  hold(pol_pkg::MODE_BANG, pol_pkg::KIND_BANG, here);
               pol_pkg::CHAR_EQUAL:
                  hold(pol_pkg::MODE_EQUAL, pol_pkg::KIND_EQUAL, here);
               pol_pkg::CHAR_GREATER:
                  hold(pol_pkg::MODE_GREATER, pol_pkg::KIND_GREATER, here);
               pol_pkg::CHAR_LESS:
                  hold(pol_pkg::MODE_LESS, pol_pkg::KIND_LESS, here);
               pol_pkg::CHAR_SLASH:
                  hold(pol_pkg::MODE_SLASH, pol_pkg::KIND_SLASH, here);
               pol_pkg::CHAR_SPACE, pol_pkg::CHAR_TAB, pol_pkg::CHAR_CR: ;
               pol_pkg::CHAR_NEWLINE: if (line != '1) line = line + 16'd1;
               default: add(pol_pkg::KIND_ERROR, here, 2'd1, sym);
            endcase
         end
      endfunction

      function void take_byte(logic [7:0] sym, logic eos);
         int                 n_prior;
         int                 tail;
         pol_pkg::token_type t;
         n_prior = expected_tokens.size();
         if (eos) begin
            if (mode != pol_pkg::MODE_NORMAL && mode != pol_pkg::MODE_COMMENT) begin
               add(held, held_start, 2'd1, 8'd0);
            end
            add(pol_pkg::KIND_END, position, 2'd0, 8'd0);
            mode       = pol_pkg::MODE_NORMAL;
            position   = '0;
            held_start = '0;
            line       = first_line;
         end else if (mode == pol_pkg::MODE_COMMENT) begin
            if (sym == pol_pkg::CHAR_NEWLINE) begin
               mode = pol_pkg::MODE_NORMAL;
               scan_byte(sym);
            end else begin
               advance();
            end
         end else if (mode == pol_pkg::MODE_SLASH && sym == pol_pkg::CHAR_SLASH) begin
            advance();
            mode = pol_pkg::MODE_COMMENT;
         end else if (mode != pol_pkg::MODE_NORMAL && mode != pol_pkg::MODE_SLASH &&
                      sym == pol_pkg::CHAR_EQUAL) begin
            advance();
            // two-character kind directly follows its one-character kind
            add(held + 5'd1, held_start, 2'd2, 8'd0);
            mode = pol_pkg::MODE_NORMAL;
         end else begin
            if (mode != pol_pkg::MODE_NORMAL) add(held, held_start, 2'd1, 8'd0);
            mode = pol_pkg::MODE_NORMAL;
            scan_byte(sym);
         end
         if (expected_tokens.size() > n_prior) begin
            tail = expected_tokens.size() - 1;
            t = expected_tokens[tail];
            t.last = 1'b1;
            expected_tokens[tail] = t;
         end
      endfunction

      function void compare(string field, logic [31:0] want, logic [31:0] got);
         if (want !== got) begin
            $error("%s: expected %0d, got %0d", field, want, got);
            failures++;
         end
      endfunction

      function void check_token(logic [4:0] kind, logic [55:0] data, logic last);
         pol_pkg::token_type e;
         if (expected_tokens.size() == 0) begin
            $error("token of kind %0d with none expected", kind);
            failures++;
            return;
         end
         e = expected_tokens.pop_front();
         compare("token_kind", 32'(e.kind), 32'(kind));
         compare("line_of_token", 32'(e.line), 32'(data[15:0]));
         compare("start_offset", 32'(e.offset), 32'(data[39:16]));
         compare("lexeme_length", 32'(e.length), 32'(data[41:40]));
         compare("bad_symbol", 32'(e.bad), 32'(data[49:42]));
         compare("last_of_run", 32'(e.last), 32'(last));
      endfunction
   endclass

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata  = '0;
   logic        req_tuser  = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [55:0] rsp_tdata;
   logic [4:0]  rsp_tuser;
   logic        rsp_tlast;
   logic        csr_we     = 1'b0;
   logic [15:0] csr_wdata  = '0;

   token_predictor tokens = new();
   int    words_sent   = 0;
   bit    steady       = 1'b0;   // no idling on either side
   bit    hold_results = 1'b0;
   string SOLO_BYTES   = "()[]{}+-*%.,;:";
   string HELD_BYTES   = "!=<>/";
   string BLANK_BYTES  = " \t\r";

   punctuation_operator_lexer dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 55) return 0;
      if (roll < 85) return $urandom_range(1, 3);
      if (roll < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   task automatic send_word(logic [7:0] sym, logic eos);
      int gap;
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata  <= sym;
      req_tuser  <= eos;
      do @(posedge clock); while (!req_tready);
      tokens.take_byte(sym, eos);
      words_sent++;
      gap = steady ? 0 : pick_gap();
      if (gap > 0) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
   endtask

   task automatic send_end();
      send_word(8'($urandom_range(0, 255)), 1'b1);
   endtask

   task automatic send_text(string s);
      for (int i = 0; i < s.len(); i++) send_word(s[i], 1'b0);
   endtask

   // mostly lexer-relevant bytes, with comments, operator pairs and some noise
   task automatic send_random_source(int count);
      int         roll;
      logic [7:0] sym;
      repeat (count) begin
         roll = $urandom_range(0, 99);
         if (roll < 40) begin
            send_word(SOLO_BYTES[$urandom_range(0, 13)], 1'b0);
         end else if (roll < 62) begin
            sym = HELD_BYTES[$urandom_range(0, 4)];
            send_word(sym, 1'b0);
            if ($urandom_range(0, 1)) send_word(pol_pkg::CHAR_EQUAL, 1'b0);
         end else if (roll < 70) begin
            send_text("//");
            repeat ($urandom_range(0, 6)) send_word(8'($urandom_range(0, 255)), 1'b0);
            if (roll < 68) send_word(pol_pkg::CHAR_NEWLINE, 1'b0);
         end else if (roll < 78) begin
            send_word(BLANK_BYTES[$urandom_range(0, 2)], 1'b0);
         end else if (roll < 85) begin
            send_word(pol_pkg::CHAR_NEWLINE, 1'b0);
         end else begin
            send_word(8'($urandom_range(0, 255)), 1'b0);
         end
      end
   endtask

   task automatic run_sources(int target);
      while (words_sent < target) begin
         send_random_source($urandom_range(0, 20));
         if ($urandom_range(0, 9) != 0) send_end();
      end
   endtask

   // stop offering words, wait for every due token, then let the queue settle
   task automatic settle();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (tokens.expected_tokens.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_start_line(logic [15:0] value);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(negedge clock);
      csr_we    <= 1'b0;
      tokens.set_first_line(value);
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) tokens.check_token(rsp_tuser, rsp_tdata, rsp_tlast);
   end

   initial begin : result_sink
      int stall_left;
      stall_left = 0;
      forever begin
         @(negedge clock);
         if (hold_results) begin
            stall_left   = 200;
            hold_results = 1'b0;
         end
         if (stall_left > 0) begin
            rsp_tready <= 1'b0;
            stall_left--;
         end else if (steady) begin
            rsp_tready <= 1'b1;
         end else if ($urandom_range(0, 99) < 25) begin
            rsp_tready <= 1'b0;
            stall_left = pick_gap();
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   initial begin : stimulus
      repeat (10) @(negedge clock);
      reset <= 1'b0;

      // held operators flushed by a following token, then every pair
      send_text("!(<)>[=]/{");
      send_text("!=<=>===");
      send_text("}+-*%.,;:");
      // comment hiding a zero byte, then zero and top byte as errors
      send_text("//");
      send_word(8'h00, 1'b0);
      send_word(pol_pkg::CHAR_NEWLINE, 1'b0);
      send_word(8'h00, 1'b0);
      send_word(8'hFF, 1'b0);
      send_text(" \t\r");
      // held operator and open comment at end of source
      send_text("<");
      send_end();
      send_text("//x");
      send_end();

      settle();
      write_start_line(16'h0000);
      run_sources(170);

      // line number saturation
      send_end();
      settle();
      write_start_line(16'hFFFE);
      send_text("\n;\n;\n;");
      send_end();
      settle();
      write_start_line(16'hFFFF);
      send_text(";\n;");
      send_end();

      // receiver holds off while words keep coming
      hold_results = 1'b1;
      steady       = 1'b1;
      repeat (40) send_word(SOLO_BYTES[$urandom_range(0, 13)], 1'b0);
      steady = 1'b0;

      // mid-source write: takes effect at the next source only
      settle();
      write_start_line(16'($urandom_range(0, 65535)));
      run_sources(360);

      steady = 1'b1;
      run_sources(440);
      steady = 1'b0;

      settle();
      write_start_line(16'($urandom_range(1, 65534)));
      run_sources(540);
      send_end();

      settle();
      repeat (16) @(posedge clock);
      if (tokens.failures == 0) begin
         $display("testbench: clean");
      end else begin
         $display("testbench: errors");
      end
      $finish;
   end

   initial begin : watchdog
      #5_000_000;
      $display("testbench: errors");
      $finish;
   end

endmodule
